// File: rtl/core/bf3_pkg.sv
`default_nettype none

package bf3_pkg;

  // pixel as stored and streamed: red in the lowest byte
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  localparam int unsigned PIX_W = $bits(pixel_t);

  // one line-store word: the row just above and the row above that
  typedef struct packed {
    pixel_t prev;
    pixel_t older;
  } line_word_t;

  localparam int unsigned LINE_W = $bits(line_word_t);

  // new right-hand window column
  typedef struct packed {
    pixel_t bot;
    pixel_t mid;
    pixel_t top;
  } column_t;

  // nine-byte sums reach 2295
  localparam int unsigned SUM_W = 12;

  typedef struct packed {
    logic [SUM_W-1:0] blue;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] red;
  } sum_pix_t;

  // floor(s / 9) == (s * 7282) >> 16 for all s up to 2295
  localparam int unsigned RECIP_W     = 16;
  localparam int unsigned RECIP_SHIFT = 16;
  localparam logic [RECIP_W-1:0] RECIP_9 = 16'd7282;
  localparam int unsigned PROD_W = SUM_W + RECIP_W;

  // frame geometry
  localparam int unsigned WIDTH_REG_W  = 12;
  localparam int unsigned HEIGHT_REG_W = 13;
  localparam int unsigned ROW_W        = 12;
  localparam int unsigned CNT_W        = 14;
  localparam int unsigned MIN_DIM      = 3;
  localparam int unsigned MAX_HEIGHT   = 4096;
  localparam int unsigned RESET_WIDTH  = 2048;
  localparam int unsigned RESET_HEIGHT = 2048;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = HEIGHT_REG_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // per-item tag travelling down the pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } tag_t;

endpackage

`default_nettype wire

// File: rtl/core/bf3_ram.sv
`default_nettype none

module bf3_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/bf3_window.sv
`default_nettype none

module bf3_window (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              adv_i,
  input  wire logic              shift_i,
  input  wire bf3_pkg::column_t  col_i,
  output      bf3_pkg::sum_pix_t sum_o
);

  import bf3_pkg::*;

  // row-major 3x3, index 2/5/8 is the newest column
  pixel_t [8:0] win_q;
  pixel_t [8:0] win_d;
  sum_pix_t     sum_q;
  sum_pix_t     sum_d;

  always_comb begin
    win_d = win_q;
    for (int k = 0; k < 3; k++) begin
      win_d[k*3]     = win_q[k*3+1];
      win_d[k*3 + 1] = win_q[k*3+2];
    end
    win_d[2] = col_i.top;
    win_d[5] = col_i.mid;
    win_d[8] = col_i.bot;
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < 9; i++) begin
      sum_d.red   = sum_d.red   + SUM_W'(win_q[i].red);
      sum_d.green = sum_d.green + SUM_W'(win_q[i].green);
      sum_d.blue  = sum_d.blue  + SUM_W'(win_q[i].blue);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (adv_i && shift_i) begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire

// File: rtl/core/bf3_mean.sv
`default_nettype none

module bf3_mean (
  input  wire bf3_pkg::sum_pix_t sum_i,
  output      bf3_pkg::pixel_t   mean_o
);

  import bf3_pkg::*;

  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_g;
  logic [PROD_W-1:0] prod_b;

  // divide by nine through the scaled reciprocal
  assign prod_r = PROD_W'(sum_i.red)   * PROD_W'(RECIP_9);
  assign prod_g = PROD_W'(sum_i.green) * PROD_W'(RECIP_9);
  assign prod_b = PROD_W'(sum_i.blue)  * PROD_W'(RECIP_9);

  assign mean_o.red   = prod_r[RECIP_SHIFT +: 8];
  assign mean_o.green = prod_g[RECIP_SHIFT +: 8];
  assign mean_o.blue  = prod_b[RECIP_SHIFT +: 8];

endmodule

`default_nettype wire

// File: rtl/core/rgb_box_filter_3x3.sv
// 3x3 box mean filter on an RGB raster stream, one pixel per clock while the output is free
// path: the input item that completes a window is registered in stage 1 beside the
// line-store read, then in the window, the channel sums and the output register
// throughput: one item per cycle, all stages advance together when the output is free
// reset: asynchronous active low; width and height return to 2048, positions to zero,
// window cleared, pipeline emptied; line stores keep contents and need no clearing pass
`default_nettype none

module rgb_box_filter_3x3 #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,

  // configuration write port
  input  wire logic                           cfg_we_i,
  input  wire logic [bf3_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [bf3_pkg::CFG_DATA_W-1:0] cfg_data_i,

  // pixel input
  input  wire logic                           s_axis_tvalid,
  output      logic                           s_axis_tready,
  input  wire logic [23:0]                    s_axis_tdata,   // red_in, green_in, blue_in

  // mean output
  output      logic                           m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output      logic [23:0]                    m_axis_tdata,   // red_out, green_out, blue_out
  output      logic                           m_axis_tlast    // frame_last
);

  import bf3_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  // ---------------------------------------------------------------------------
  // configuration and frame geometry
  // ---------------------------------------------------------------------------
  logic [WIDTH_REG_W-1:0]  width_q;
  logic [HEIGHT_REG_W-1:0] height_q;
  logic [CNT_W-1:0]        width_ext;
  logic [CNT_W-1:0]        w_eff;
  logic [HEIGHT_REG_W-1:0] h_eff;

  assign width_ext = CNT_W'(width_q);

  // clamp to the supported frame size
  always_comb begin
    if (width_ext < CNT_W'(MIN_DIM)) begin
      w_eff = CNT_W'(MIN_DIM);
    end else if (width_ext > CNT_W'(MAX_WIDTH)) begin
      w_eff = CNT_W'(MAX_WIDTH);
    end else begin
      w_eff = width_ext;
    end
  end

  always_comb begin
    if (height_q < HEIGHT_REG_W'(MIN_DIM)) begin
      h_eff = HEIGHT_REG_W'(MIN_DIM);
    end else if (height_q > HEIGHT_REG_W'(MAX_HEIGHT)) begin
      h_eff = HEIGHT_REG_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline control: every stage moves when the output register can take data
  // ---------------------------------------------------------------------------
  logic adv;
  logic acc;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign acc           = s_axis_tvalid && adv;

  // ---------------------------------------------------------------------------
  // raster position of the incoming item
  // ---------------------------------------------------------------------------
  logic [AW-1:0]    col_q;
  logic [ROW_W-1:0] row_q;
  logic             col_end;
  logic             row_end;
  logic             emit;

  assign col_end = (CNT_W'(col_q) + CNT_W'(1)) >= w_eff;
  assign row_end = (HEIGHT_REG_W'(row_q) + HEIGHT_REG_W'(1)) >= h_eff;
  // window is complete from row 2, column 2 on
  assign emit    = (CNT_W'(col_q) >= CNT_W'(2)) && (row_q >= ROW_W'(2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_REG_W'(RESET_WIDTH);
      height_q <= HEIGHT_REG_W'(RESET_HEIGHT);
      col_q    <= '0;
      row_q    <= '0;
    end else if (cfg_we_i) begin
      // any register write restarts the frame
      case (cfg_reg_e'(cfg_index_i))
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
      col_q <= '0;
      row_q <= '0;
    end else if (acc) begin
      if (col_end) begin
        col_q <= '0;
        row_q <= row_end ? '0 : row_q + ROW_W'(1);
      end else begin
        col_q <= col_q + AW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: line store read in flight
  // ---------------------------------------------------------------------------
  logic       s1_valid_q;
  tag_t       s1_tag_q;
  pixel_t     s1_pix_q;
  logic [AW-1:0] s1_addr_q;
  line_word_t rd_word;
  line_word_t wr_word;
  logic       st_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_tag_q   <= '0;
    end else if (adv) begin
      s1_valid_q     <= acc;
      s1_tag_q.valid <= acc && emit;
      s1_tag_q.last  <= row_end && col_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_pix_q  <= s_axis_tdata;
      s1_addr_q <= col_q;
    end
  end

  // read-modify-write: the row above moves to the older slot, the new pixel in
  // the same column is touched again only a full row later, so no forwarding
  assign st_we         = adv && s1_valid_q;
  assign wr_word.prev  = s1_pix_q;
  assign wr_word.older = rd_word.prev;

  bf3_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (s1_addr_q),
    .wdata_i (wr_word),
    .re_i    (acc),
    .raddr_i (col_q),
    .rdata_o (rd_word)
  );

  // ---------------------------------------------------------------------------
  // stage 2: window update, stage 3: channel sums
  // ---------------------------------------------------------------------------
  column_t  new_col;
  sum_pix_t sum;
  tag_t     win_tag_q;
  tag_t     sum_tag_q;

  assign new_col.top = rd_word.older;
  assign new_col.mid = rd_word.prev;
  assign new_col.bot = s1_pix_q;

  bf3_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .shift_i (s1_valid_q),
    .col_i   (new_col),
    .sum_o   (sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_tag_q <= '0;
      sum_tag_q <= '0;
    end else if (adv) begin
      win_tag_q <= s1_tag_q;
      sum_tag_q <= win_tag_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: divide by nine into the output register
  // ---------------------------------------------------------------------------
  pixel_t mean;
  pixel_t out_pix_q;
  logic   out_valid_q;
  logic   out_last_q;

  bf3_mean u_mean (
    .sum_i  (sum),
    .mean_o (mean)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else if (adv) begin
      out_valid_q <= sum_tag_q.valid;
      out_last_q  <= sum_tag_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_pix_q <= mean;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// File: sim/rgb_box_filter_3x3_tb.sv
`timescale 1ns / 1ps

module rgb_box_filter_3x3_tb;
  import bf3_pkg::*;

  // line-store depth of the block under test
  localparam int unsigned MAX_W = 2048;
  // idle cycles allowed after the last mean before a register write
  localparam int unsigned SETTLE_CYCLES = 8;
  // length of the long output hold-off, enough to back up the whole pipeline
  localparam int unsigned HOLD_CYCLES = 300;
  // watchdog, far above the slowest correct run
  localparam int unsigned CYCLE_LIMIT = 1000000;

  // one expected mean item
  typedef struct packed {
    logic   last;
    pixel_t mean;
  } mean_item_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;

  logic        cfg_we_i = 1'b0;
  cfg_reg_e    cfg_index_i = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  pixel_t      s_axis_tdata = '0;    // red_in, green_in, blue_in

  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // red_out, green_out, blue_out
  logic        m_axis_tlast;         // frame_last

  // pixels waiting to be offered, and means still to come back
  pixel_t      pixel_q[$];
  mean_item_t  mean_q[$];

  // idle shaping, set per phase by the sequence
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  // long hold-off requests, counted so the receiver picks each one up once
  int unsigned hold_ask = 0;

  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;

  // filter state as the predictor sees it
  logic [WIDTH_REG_W-1:0]  width_reg = 12'(RESET_WIDTH);
  logic [HEIGHT_REG_W-1:0] height_reg = 13'(RESET_HEIGHT);
  pixel_t      line_prev [MAX_W];
  pixel_t      line_older [MAX_W];
  pixel_t      win [3][3] = '{default: '0};
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;

  rgb_box_filter_3x3 #(
    .MAX_WIDTH(MAX_W)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // geometry registers clamp into the range the block supports
  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  // advance the filter by one pixel; queue a mean when the window is complete
  task automatic predict_mean(input pixel_t px);
    int unsigned w;
    int unsigned h;
    pixel_t      top;
    pixel_t      mid;
    logic [SUM_W-1:0] sr;
    logic [SUM_W-1:0] sg;
    logic [SUM_W-1:0] sb;
    mean_item_t  res;
    w = clamp_dim(width_reg, MAX_W);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    top = line_older[col_pos];
    mid = line_prev[col_pos];
    // slide the window left and load the new right column
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = px;
    line_older[col_pos] = mid;
    line_prev[col_pos] = px;
    // only interior pixels give a mean: the window needs two rows and two columns
    if (row_pos >= 2 && col_pos >= 2) begin
      sr = '0;
      sg = '0;
      sb = '0;
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          sr += win[k][j].red;
          sg += win[k][j].green;
          sb += win[k][j].blue;
        end
      end
      res.mean.red = 8'(sr / 9);
      res.mean.green = 8'(sg / 9);
      res.mean.blue = 8'(sb / 9);
      res.last = (row_pos + 1 >= h) && (col_pos + 1 >= w);
      mean_q.push_back(res);
    end
    // raster position, wrapping at the end of the frame
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endtask

  // pixel driver: a new item goes out only once the current one is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pixel_q.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // mean receiver: random stalls plus the occasional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin : recv_blk
    int unsigned hold_left;
    int unsigned hold_taken;
    if (!rst_ni) begin
      hold_left = 0;
      hold_taken = 0;
      m_axis_tready <= 1'b0;
    end else begin
      if (hold_left == 0 && hold_taken != hold_ask) begin
        hold_left = HOLD_CYCLES;
        hold_taken++;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // monitor: check each mean against the oldest prediction, then predict
  // from the pixel taken at this edge
  always @(posedge clk_i) begin : mon_blk
    mean_item_t want;
    pixel_t     got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (mean_q.size() == 0) begin
          $display("%0t: unexpected mean item, expected none, got %h last %b",
                   $time, got, m_axis_tlast);
          err_cnt++;
        end else begin
          want = mean_q.pop_front();
          if (got.red !== want.mean.red) begin
            $display("%0t: red mean expected %0d got %0d", $time, want.mean.red, got.red);
            err_cnt++;
          end
          if (got.green !== want.mean.green) begin
            $display("%0t: green mean expected %0d got %0d", $time, want.mean.green,
                     got.green);
            err_cnt++;
          end
          if (got.blue !== want.mean.blue) begin
            $display("%0t: blue mean expected %0d got %0d", $time, want.mean.blue, got.blue);
            err_cnt++;
          end
          if (m_axis_tlast !== want.last) begin
            $display("%0t: frame last expected %b got %b", $time, want.last, m_axis_tlast);
            err_cnt++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_mean(s_axis_tdata);
    end
  end

  // bytes lean toward the extremes so both ends of the sum are hit often
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic push_pixels(input int unsigned n);
    pixel_t px;
    repeat (n) begin
      px.red = rand_byte();
      px.green = rand_byte();
      px.blue = rand_byte();
      pixel_q.push_back(px);
    end
  endtask

  // register write while idle; any write restarts the frame at the top-left pixel
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) width_reg = val[WIDTH_REG_W-1:0];
    else height_reg = val;
    col_pos = 0;
    row_pos = 0;
    @(negedge clk_i);
  endtask

  // sender holds back until every pixel is taken and every mean is back,
  // then waits out the settle time, since border pixels may still be in flight
  task automatic wait_drain();
    while (pixel_q.size() != 0 || s_axis_tvalid || mean_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // frame sizes: mostly small, sometimes below the minimum or somewhat larger
  function automatic int unsigned pick_dim(int unsigned common_hi, int unsigned rare_hi);
    case ($urandom_range(9))
      0: return $urandom_range(0, 2);
      1: return $urandom_range(common_hi + 1, rare_hi);
      default: return $urandom_range(MIN_DIM, common_hi);
    endcase
  endfunction

  // random frames with random geometry; whole frames mostly, now and then a
  // truncated one that the next register write cuts off
  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input int unsigned target, input bit long_hold);
    int unsigned sent;
    int unsigned w;
    int unsigned h;
    int unsigned n;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    while (sent < target) begin
      w = pick_dim(10, 24);
      h = pick_dim(6, 12);
      if ($urandom_range(1)) begin
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
      end else begin
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
      end
      w = clamp_dim(w, MAX_W);
      h = clamp_dim(h, MAX_HEIGHT);
      n = $urandom_range(1, 3) * w * h;
      if ($urandom_range(4) == 0) n += $urandom_range(1, w * h - 1);
      // the phase stops at its item budget, cutting the last frame short
      if (n > target - sent) n = target - sent;
      push_pixels(n);
      // first frame of the phase: stop taking means while pixels keep coming
      if (long_hold && sent == 0) hold_ask++;
      sent += n;
      wait_drain();
    end
  endtask

  initial begin
    pixel_t px;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset geometry 2048 x 2048: part of the first row, no window completes
    push_pixels(24);
    wait_drain();

    // width and height below the minimum give a 3x3 frame, all bytes full scale
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(0));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(2));
    px = '1;
    repeat (9) pixel_q.push_back(px);
    wait_drain();

    // a partial frame, then a write mid-frame restarts at the corner
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(5));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(4));
    push_pixels(5);
    wait_drain();
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(4));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(3));
    push_pixels(12);
    wait_drain();

    // widest row: 4095 clamps to the line-store depth, height 0 clamps to 3;
    // a short run stays inside the first row
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(4095));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(0));
    push_pixels(24);
    wait_drain();

    // tall frame: 8191 clamps to 4096 rows of three pixels, the first eight rows
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(3));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(8191));
    push_pixels(3 * 8);
    wait_drain();

    // random frames under each idle pattern
    run_phase(0, 0, 188, 1'b1);
    run_phase(78, 0, 188, 1'b0);
    run_phase(0, 78, 188, 1'b1);
    run_phase(25, 25, 188, 1'b0);

    wait_drain();
    repeat (10) @(negedge clk_i);
    if (err_cnt == 0 && mean_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: rgb_box_filter_3x3.f
rtl/core/bf3_pkg.sv
rtl/core/bf3_ram.sv
rtl/core/bf3_window.sv
rtl/core/bf3_mean.sv
rtl/core/rgb_box_filter_3x3.sv
sim/rgb_box_filter_3x3_tb.sv
